// File: hw/rtl/exp2_taylor_unit_core_defines.svh
// Assertion macros shared by the exp2 Taylor unit RTL.
// Expects signals clk and arst_n in the scope of each use.
`ifndef EXP2_TAYLOR_UNIT_CORE_DEFINES_SVH
`define EXP2_TAYLOR_UNIT_CORE_DEFINES_SVH

// Same-cycle implication.
`define E2T_ASSERT_IMPL(LBL, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge clk) disable iff (!arst_n) (ANTE) |-> (CONS)) else $error(MSG);

// Next-cycle implication.
`define E2T_ASSERT_NEXT(LBL, ANTE, CONS, MSG) \
	LBL: assert property (@(posedge clk) disable iff (!arst_n) (ANTE) |=> (CONS)) else $error(MSG);

`endif

// File: hw/rtl/e2t_pkg.sv
// Package for the exp2 Taylor unit: widths, constants and link types.
// No dependencies; used by every other RTL file but the defines header.
package e2t_pkg;

	localparam int unsigned POWER_W = 32;
	localparam int unsigned MANT_W  = 32;
	localparam int unsigned EXP_W   = 12;
	localparam int unsigned LIMIT_W = 12;
	localparam int unsigned TERM_W  = 32;
	localparam int unsigned SUM_W   = 36;

	localparam int unsigned TAYLOR_TERMS_DEF  = 16;
	localparam int unsigned FRACTION_BITS_DEF = 20;

	// round(ln2 * 2^32)
	localparam logic [TERM_W-1:0] LN2_Q32 = 32'd2977044472;
	// 1.0 in Q32, start of the series sum
	localparam logic signed [SUM_W-1:0] ONE_Q32 = 36'sh1_0000_0000;

	localparam logic [EXP_W-1:0]        EXP_SAT_MAG = 12'h800;
	localparam logic signed [EXP_W-1:0] EXP_MAX     = 12'sh7FF;

	localparam logic signed [LIMIT_W-1:0] OVF_LIMIT_RST = 12'sd1024;
	localparam logic signed [LIMIT_W-1:0] UNF_LIMIT_RST = -12'sd1021;

	typedef struct packed {
		logic                    neg;
		logic                    ovf;
		logic                    unf;
		logic signed [EXP_W-1:0] exponent;
	} e2t_ctl_t;

	// What moves from cell to cell: control, |y|, pending term, partial sum.
	typedef struct packed {
		e2t_ctl_t                ctl;
		logic [TERM_W-1:0]       ymag;
		logic [TERM_W-1:0]       term;
		logic signed [SUM_W-1:0] sum;
	} e2t_link_t;

endpackage

// File: hw/rtl/e2t_ifs.sv
// Valid/ready channel interfaces for the exp2 Taylor unit.
// Depends on e2t_pkg.
interface e2t_in_if import e2t_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [POWER_W-1:0] power;

	modport source (output valid, output power, input ready);
	modport sink (input valid, input power, output ready);
endinterface

interface e2t_out_if import e2t_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [MANT_W-1:0]       mantissa;
	logic signed [EXP_W-1:0] exponent;
	logic                    overflow;
	logic                    underflow_zero;

	modport source (output valid, output mantissa, output exponent, output overflow,
		output underflow_zero, input ready);
	modport sink (input valid, input mantissa, input exponent, input overflow,
		input underflow_zero, output ready);
endinterface

// File: hw/rtl/e2t_front.sv
// Front end: limit checks, integer/fraction split, |y| = |frac| * ln2.
// Three stages. Depends on e2t_pkg.
module e2t_front import e2t_pkg::*; #(
	parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [POWER_W-1:0] power,
	input  logic signed [LIMIT_W-1:0] overflow_limit,
	input  logic signed [LIMIT_W-1:0] underflow_limit,
	output logic                      dn_valid,
	output e2t_link_t                 dn
);

	localparam int unsigned FH     = FRACTION_BITS / 2;
	localparam int unsigned FL     = FRACTION_BITS - FH;
	localparam int unsigned CMP_W  = POWER_W + LIMIT_W + FRACTION_BITS;
	localparam int unsigned MAGX_W = POWER_W + FRACTION_BITS;
	localparam int unsigned PW     = FRACTION_BITS + TERM_W + 1;

	// stage 1 logic
	logic signed [CMP_W-1:0]  pwr_cmp, ovl_cmp, unl_cmp;
	logic                     neg, ovf, unf;
	logic [POWER_W-1:0]       mag;
	logic [MAGX_W-1:0]        mag_ext, ipart_mag;
	logic [EXP_W-1:0]         ipart_sat;
	logic signed [EXP_W-1:0]  exponent;
	// stage 3 logic
	logic [PW-1:0]            yprod;

	logic                     valid_s1, valid_s2, valid_s3;
	e2t_ctl_t                 ctl_s1, ctl_s2;
	logic [FRACTION_BITS-1:0] fmag_s1;
	logic [FH+TERM_W-1:0]     lo_s2;
	logic [FL+TERM_W-1:0]     hi_s2;
	e2t_link_t                link_s3;

	always_comb begin
		pwr_cmp = CMP_W'(power);
		ovl_cmp = CMP_W'(overflow_limit) <<< FRACTION_BITS;
		unl_cmp = CMP_W'(underflow_limit) <<< FRACTION_BITS;
		ovf     = pwr_cmp >= ovl_cmp;
		unf     = !ovf && (pwr_cmp < unl_cmp);

		neg       = power[POWER_W-1];
		mag       = neg ? POWER_W'(-power) : POWER_W'(power);
		mag_ext   = MAGX_W'(mag);
		ipart_mag = mag_ext >> FRACTION_BITS;
		ipart_sat = (ipart_mag > MAGX_W'(EXP_SAT_MAG)) ? EXP_SAT_MAG : ipart_mag[EXP_W-1:0];
		if (unf) begin
			exponent = '0;
		end else if (neg) begin
			exponent = -$signed(ipart_sat);
		end else if (ipart_sat == EXP_SAT_MAG) begin
			exponent = EXP_MAX;
		end else begin
			exponent = $signed(ipart_sat);
		end
	end

	always_comb begin
		yprod = (PW'(hi_s2) << FH) + PW'(lo_s2) + (PW'(1) << (FRACTION_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.neg      <= neg;
			ctl_s1.ovf      <= ovf;
			ctl_s1.unf      <= unf;
			ctl_s1.exponent <= exponent;
			fmag_s1         <= mag_ext[FRACTION_BITS-1:0];

			ctl_s2 <= ctl_s1;
			lo_s2  <= (FH+TERM_W)'(fmag_s1[FH-1:0]) * (FH+TERM_W)'(LN2_Q32);
			hi_s2  <= (FL+TERM_W)'(fmag_s1[FRACTION_BITS-1:FH]) * (FL+TERM_W)'(LN2_Q32);

			link_s3.ctl  <= ctl_s2;
			link_s3.ymag <= TERM_W'(yprod >> FRACTION_BITS);
			link_s3.term <= TERM_W'(yprod >> FRACTION_BITS);  // first term is y itself
			link_s3.sum  <= ONE_Q32;
		end
	end

	assign dn_valid = valid_s3;
	assign dn       = link_s3;

endmodule

// File: hw/rtl/e2t_cell.sv
// One Taylor cell: folds in the pending term, then builds the next term
// t = round(round(t*|y| / 2^32) / INDEX). Four stages. Depends on e2t_pkg.
module e2t_cell import e2t_pkg::*; #(
	parameter int unsigned INDEX = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      up_valid,
	input  e2t_link_t up,
	output logic      dn_valid,
	output e2t_link_t dn
);

	localparam int unsigned C = $clog2(INDEX);
	localparam int unsigned K = TERM_W + C;
	// floor(2^K / INDEX); quotient from it is low by at most one
	localparam logic [TERM_W:0]   RECIP   = (TERM_W+1)'(((2*TERM_W+6)'(1) << K) / INDEX);
	localparam logic [TERM_W-1:0] HALF    = TERM_W'(INDEX / 2);
	localparam logic [TERM_W-1:0] DIVISOR = TERM_W'(INDEX);
	// pending term carries index INDEX-1; odd indexes subtract for negative y
	localparam bit PEND_ODD = ((INDEX - 1) % 2) == 1;

	logic signed [SUM_W-1:0]  term_ext, sum_next;
	logic [2*TERM_W:0]        rnd;
	logic [2*TERM_W:0]        qprod;
	logic [TERM_W-1:0]        rem, q;

	logic                     valid_s1, valid_s2, valid_s3, valid_s4;
	e2t_link_t                link_s1, link_s2, link_s3, link_s4;
	logic [2*TERM_W-1:0]      prod_s1;
	logic [TERM_W-1:0]        n_s2, n_s3, q0_s3;

	always_comb begin
		term_ext = SUM_W'(up.term);
		sum_next = (PEND_ODD && up.ctl.neg) ? up.sum - term_ext : up.sum + term_ext;
	end

	always_comb begin
		// < 2^32 once the index is two or more, so the truncation is exact
		rnd   = (2*TERM_W+1)'(prod_s1) + (2*TERM_W+1)'(33'h0_8000_0000);
		qprod = (2*TERM_W+1)'(n_s2) * (2*TERM_W+1)'(RECIP);
		rem   = n_s3 - TERM_W'(q0_s3 * DIVISOR);
		q     = (rem >= DIVISOR) ? q0_s3 + TERM_W'(1) : q0_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			link_s1.ctl  <= up.ctl;
			link_s1.ymag <= up.ymag;
			link_s1.term <= up.term;
			link_s1.sum  <= sum_next;
			prod_s1      <= (2*TERM_W)'(up.term) * (2*TERM_W)'(up.ymag);

			link_s2 <= link_s1;
			n_s2    <= TERM_W'(rnd >> TERM_W) + HALF;

			link_s3 <= link_s2;
			n_s3    <= n_s2;
			q0_s3   <= TERM_W'(qprod >> K);

			link_s4.ctl  <= link_s3.ctl;
			link_s4.ymag <= link_s3.ymag;
			link_s4.sum  <= link_s3.sum;
			link_s4.term <= q;
		end
	end

	assign dn_valid = valid_s4;
	assign dn       = link_s4;

endmodule

// File: hw/rtl/e2t_tail.sv
// Tail: adds the last term, rounds Q32 to Q2.30, clamps, applies the flags.
// Second stage is the output register. Depends on e2t_pkg.
module e2t_tail import e2t_pkg::*; #(
	parameter int unsigned TAYLOR_TERMS = TAYLOR_TERMS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    up_valid,
	input  e2t_link_t               up,
	output logic                    valid,
	output logic [MANT_W-1:0]       mantissa,
	output logic signed [EXP_W-1:0] exponent,
	output logic                    overflow,
	output logic                    underflow_zero
);

	localparam bit LAST_ODD = (TAYLOR_TERMS % 2) == 1;

	logic signed [SUM_W-1:0] term_ext, sum_next, rsum;
	logic [MANT_W-1:0]       mant;

	logic                    valid_s1, valid_q;
	e2t_ctl_t                ctl_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic [MANT_W-1:0]       mantissa_q;
	logic signed [EXP_W-1:0] exponent_q;
	logic                    overflow_q, underflow_zero_q;

	always_comb begin
		term_ext = SUM_W'(up.term);
		sum_next = (LAST_ODD && up.ctl.neg) ? up.sum - term_ext : up.sum + term_ext;
	end

	always_comb begin
		rsum = (sum_s1 + SUM_W'(2)) >>> 2;
		if (ctl_s1.ovf) begin
			mant = '1;
		end else if (ctl_s1.unf || sum_s1[SUM_W-1]) begin
			mant = '0;
		end else if (rsum > SUM_W'({MANT_W{1'b1}})) begin
			mant = '1;
		end else begin
			mant = rsum[MANT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
			valid_q  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1           <= up.ctl;
			sum_s1           <= sum_next;
			mantissa_q       <= mant;
			exponent_q       <= ctl_s1.exponent;
			overflow_q       <= ctl_s1.ovf;
			underflow_zero_q <= ctl_s1.unf;
		end
	end

	assign valid          = valid_q;
	assign mantissa       = mantissa_q;
	assign exponent       = exponent_q;
	assign overflow       = overflow_q;
	assign underflow_zero = underflow_zero_q;

endmodule

// File: hw/rtl/exp2_taylor_unit_core.sv
// exp2_taylor_unit_core: 2^power for a signed fixed-point power (Q11.20 by
// default). Result is a Q2.30 mantissa = 2^fraction plus the integer part as
// exponent, both parts truncated toward zero. The series for e^y runs down a
// row of TAYLOR_TERMS-1 identical cells; each cell adds the pending term into
// the running sum and forms the next term with one 32x32 multiply and a
// reciprocal divide by its own constant index. One item enters per cycle
// while the output does not stall: the whole pipe advances when the output
// register is empty or being taken, so a stall on the output stalls the
// input. Limits are set through the APB port: 0x0 overflow_limit, 0x4
// underflow_limit, both 12-bit signed, read back sign-extended. Overflow
// wins over underflow; overflow gives an all-ones mantissa, underflow a zero
// mantissa and exponent.
// Depends on e2t_pkg, e2t_ifs, e2t_front, e2t_cell, e2t_tail and the defines.
`include "exp2_taylor_unit_core_defines.svh"

module exp2_taylor_unit_core import e2t_pkg::*; #(
	parameter int unsigned TAYLOR_TERMS  = TAYLOR_TERMS_DEF,
	parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	e2t_in_if.sink      din,
	e2t_out_if.source   dout,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// register select: paddr[2]
	localparam logic REG_OVF_LIMIT = 1'b0;
	localparam logic REG_UNF_LIMIT = 1'b1;

	logic signed [LIMIT_W-1:0] ovl_q, unl_q;
	logic                      cfg_wr;
	logic                      en;

	logic                      out_valid;
	logic [MANT_W-1:0]         out_mantissa;
	logic signed [EXP_W-1:0]   out_exponent;
	logic                      out_overflow, out_underflow_zero;

	logic [TAYLOR_TERMS:1]     link_valid;
	e2t_link_t                 link [1:TAYLOR_TERMS];

	// ---- configuration ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_q <= OVF_LIMIT_RST;
			unl_q <= UNF_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_OVF_LIMIT: ovl_q <= pwdata[LIMIT_W-1:0];
				REG_UNF_LIMIT: unl_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_OVF_LIMIT: prdata = 32'(ovl_q);
			REG_UNF_LIMIT: prdata = 32'(unl_q);
			default:       prdata = '0;
		endcase
	end

	// ---- pipeline advance: the output register frees up or is taken ----
	assign en        = !out_valid || dout.ready;
	assign din.ready = en;

	// split and |y|; link 1 holds term 1 = y and sum = 1.0
	e2t_front #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (din.valid),
		.power           (din.power),
		.overflow_limit  (ovl_q),
		.underflow_limit (unl_q),
		.dn_valid        (link_valid[1]),
		.dn              (link[1])
	);

	// cell k takes term k-1 in and hands term k on
	for (genvar k = 2; k <= TAYLOR_TERMS; k++) begin : g_cell
		e2t_cell #(
			.INDEX(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (link_valid[k-1]),
			.up       (link[k-1]),
			.dn_valid (link_valid[k]),
			.dn       (link[k])
		);
	end

	e2t_tail #(
		.TAYLOR_TERMS(TAYLOR_TERMS)
	) u_tail (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.up_valid       (link_valid[TAYLOR_TERMS]),
		.up             (link[TAYLOR_TERMS]),
		.valid          (out_valid),
		.mantissa       (out_mantissa),
		.exponent       (out_exponent),
		.overflow       (out_overflow),
		.underflow_zero (out_underflow_zero)
	);

	assign dout.valid          = out_valid;
	assign dout.mantissa       = out_mantissa;
	assign dout.exponent       = out_exponent;
	assign dout.overflow       = out_overflow;
	assign dout.underflow_zero = out_underflow_zero;

	// ---- checks ----
	`E2T_ASSERT_IMPL(a_ovf_saturates, out_valid && out_overflow, !out_underflow_zero && (out_mantissa == '1), "overflow item without saturated mantissa")
	`E2T_ASSERT_IMPL(a_unf_zeroes, out_valid && out_underflow_zero, (out_mantissa == '0) && (out_exponent == '0), "underflow item not zeroed")
	`E2T_ASSERT_NEXT(a_cfg_ovl_write, cfg_wr && (paddr[2] == REG_OVF_LIMIT), ovl_q == $past(pwdata[LIMIT_W-1:0]), "overflow limit write lost")

endmodule

// File: verif/exp2_taylor_unit_core_tb.sv
// Self-checking testbench for exp2_taylor_unit_core: random and corner powers,
// several limit settings, and a scoreboard that predicts 2^power in fixed point.
// Depends on e2t_pkg, e2t_ifs and the exp2_taylor_unit_core RTL.
`timescale 1ns / 100ps

localparam int unsigned TB_FRAC_BITS = e2t_pkg::FRACTION_BITS_DEF;
localparam int unsigned TB_TERMS     = e2t_pkg::TAYLOR_TERMS_DEF;

// APB byte addresses of the limit registers
typedef enum logic [2:0] {
	LIM_OVF_ADDR = 3'h0,
	LIM_UNF_ADDR = 3'h4
} lim_addr_t;

typedef struct {
	logic [e2t_pkg::MANT_W-1:0]       mantissa;
	logic signed [e2t_pkg::EXP_W-1:0] exponent;
	logic                             overflow;
	logic                             underflow_zero;
} exp2_res_t;

class exp2_scoreboard;
	longint    ovf_lim;
	longint    unf_lim;
	exp2_res_t exp2_due[$];
	int        mism;
	int        n_powers;
	int        n_results;
	int        n_ovf;
	int        n_unf;

	function new();
		ovf_lim = 1024;
		unf_lim = -1021;
	endfunction

	// Registers keep 12 bits, sign-extended
	function void set_limit(lim_addr_t a, logic [31:0] v);
		case (a)
			LIM_OVF_ADDR: ovf_lim = longint'($signed(v[11:0]));
			LIM_UNF_ADDR: unf_lim = longint'($signed(v[11:0]));
			default: ;
		endcase
	endfunction

	function exp2_res_t exp2_of_power(logic signed [e2t_pkg::POWER_W-1:0] pw);
		exp2_res_t            r;
		longint               p;
		longint               ipart;
		longint               sum;
		longint               scale;
		longint unsigned      mag;
		longint unsigned      imag;
		longint unsigned      fmag;
		longint unsigned      ymag;
		longint unsigned      term;
		longint unsigned      mant;
		longint unsigned      ln2;
		bit                   neg;
		p     = pw;
		neg   = p < 0;
		mag   = neg ? -p : p;
		scale = longint'(1) << TB_FRAC_BITS;
		imag  = mag >> TB_FRAC_BITS;
		fmag  = mag & ((64'd1 << TB_FRAC_BITS) - 64'd1);
		ln2   = 64'(e2t_pkg::LN2_Q32);
		// integer part toward zero, saturated to the exponent range
		if (imag > 2048)
			imag = 2048;
		ipart = neg ? -longint'(imag) : longint'(imag);
		if (ipart > 2047)
			ipart = 2047;
		r.overflow       = 1'b0;
		r.underflow_zero = 1'b0;
		r.exponent       = ipart[11:0];
		mant             = 0;
		// overflow is tested first, so it wins when both limits apply
		if (p >= ovf_lim * scale) begin
			r.overflow = 1'b1;
			mant       = 64'hFFFF_FFFF;
		end else if (p < unf_lim * scale) begin
			r.underflow_zero = 1'b1;
			r.exponent       = '0;
		end else begin
			// |y| = |frac| * ln2 in Q32, then the series for e^y
			ymag = (fmag * ln2 + (64'd1 << (TB_FRAC_BITS - 1))) >> TB_FRAC_BITS;
			term = 64'd1 << 32;
			sum  = longint'(1) << 32;
			for (longint unsigned k = 1; k <= TB_TERMS; k++) begin
				term = (term * ymag + 64'h8000_0000) >> 32;
				term = (term + k / 2) / k;
				// odd terms flip sign for negative y
				if (neg && k[0])
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			if (sum >= 0) begin
				mant = (unsigned'(sum) + 64'd2) >> 2;
				if (mant > 64'hFFFF_FFFF)
					mant = 64'hFFFF_FFFF;
			end
		end
		r.mantissa = mant[31:0];
		return r;
	endfunction

	function void note_power(logic signed [e2t_pkg::POWER_W-1:0] pw);
		exp2_due.push_back(exp2_of_power(pw));
		n_powers++;
	endfunction

	function void check_result(exp2_res_t got);
		exp2_res_t want;
		n_results++;
		if (exp2_due.size() == 0) begin
			mism++;
			$display("%0t: result with nothing pending: mant %h exp %0d ovf %b unf %b",
				$time, got.mantissa, got.exponent, got.overflow, got.underflow_zero);
			return;
		end
		want = exp2_due.pop_front();
		n_ovf += want.overflow;
		n_unf += want.underflow_zero;
		if (got.mantissa !== want.mantissa || got.exponent !== want.exponent ||
				got.overflow !== want.overflow || got.underflow_zero !== want.underflow_zero) begin
			mism++;
			$display("%0t: mismatch expected mant %h exp %0d ovf %b unf %b, actual mant %h exp %0d ovf %b unf %b",
				$time, want.mantissa, want.exponent, want.overflow, want.underflow_zero,
				got.mantissa, got.exponent, got.overflow, got.underflow_zero);
		end
	endfunction

	function int pending();
		return exp2_due.size();
	endfunction
endclass

module exp2_taylor_unit_core_tb;
	import e2t_pkg::*;

	localparam int STALL_LIMIT  = 4000;  // cycles with no item moving
	localparam int DRAIN_CYCLES = 80;    // longer than the pipeline latency
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	bit             steady;      // no idling on either side while set
	int             stall_cnt;
	exp2_scoreboard sb;

	e2t_in_if  din_ch();
	e2t_out_if dout_ch();

	exp2_taylor_unit_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din_ch),
		.dout    (dout_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Receiver: random backpressure, none while steady
	always @(posedge clk) begin
		dout_ch.ready <= steady || ($urandom_range(99) >= 31);
	end

	// Sample at the falling edge: inputs and outputs only move at the rising one,
	// so the values here are the ones the next rising edge will act on.
	always @(negedge clk) begin
		exp2_res_t got;
		if (!arst_n) begin
			stall_cnt = 0;
		end else begin
			if (dout_ch.valid && dout_ch.ready) begin
				got.mantissa       = dout_ch.mantissa;
				got.exponent       = dout_ch.exponent;
				got.overflow       = dout_ch.overflow;
				got.underflow_zero = dout_ch.underflow_zero;
				sb.check_result(got);
			end
			if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready))
				stall_cnt = 0;
			else
				stall_cnt++;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: watchdog, nothing moved for %0d cycles, %0d results pending",
					$time, STALL_LIMIT, sb.pending());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// One item on the input channel, with random idle cycles ahead of it
	task automatic send_power(input logic [31:0] pw);
		bit fire;
		while (!steady && $urandom_range(99) < 31) begin
			din_ch.valid <= 1'b0;
			@(posedge clk);
		end
		din_ch.valid <= 1'b1;
		din_ch.power <= pw;
		do begin
			@(negedge clk);
			fire = din_ch.valid && din_ch.ready;
			@(posedge clk);
		end while (!fire);
		sb.note_power(pw);
	endtask

	// Hold the input off until every pending result has come out
	task automatic drain();
		din_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// APB write: setup cycle, then access; lands on the edge ending the access
	task automatic write_limit(input lim_addr_t a, input int v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_limit(a, 32'(v));
	endtask

	// Mix of full-range powers, integer parts around the limits, exact limit
	// crossings and pure fractions.
	function automatic logic [31:0] rand_power(int ovf, int unf);
		int sel;
		int lo;
		int hi;
		int ip;
		int fr;
		int lim;
		sel = $urandom_range(99);
		if (sel < 30)
			return $urandom;
		if (sel < 75) begin
			lo = (unf < ovf) ? unf - 2 : ovf - 2;
			hi = (unf < ovf) ? ovf + 2 : unf + 2;
			if (lo < -2048) lo = -2048;
			if (hi > 2047) hi = 2047;
			ip = lo + int'($urandom_range(hi - lo));
			fr = $urandom_range(3) == 0 ? ($urandom_range(1) ? 0 : 20'hFFFFF)
				: $urandom_range(20'hFFFFF);
			return 32'(ip * (1 << TB_FRAC_BITS) + fr);
		end
		if (sel < 90) begin
			lim = $urandom_range(1) ? ovf : unf;
			return 32'(lim * (1 << TB_FRAC_BITS) + int'($urandom_range(2)) - 1);
		end
		fr = $urandom_range(20'hFFFFF);
		return $urandom_range(1) ? 32'(fr) : 32'(-fr);
	endfunction

	initial begin
		logic [31:0] corner_powers[] = '{
			32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h000F_FFFF, 32'hFFF0_0001, 32'h0010_0000, 32'hFFF0_0000, 32'h0008_0000,
			32'hFFF8_0000, 32'h4000_0000, 32'h3FFF_FFFF, 32'hC030_0000, 32'hC02F_FFFF,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h000A_3D70, 32'hFFF5_C290
		};
		int ovf_tab[PHASES] = '{1024, 2047, 0, -2048, 5, 1024, 0, 0};
		int unf_tab[PHASES] = '{-1021, -2048, 0, 2047, -5, -1024, 0, 0};
		int ovf;
		int unf;
		int n_settings;

		sb            = new();
		arst_n        = 1'b0;
		steady        = 1'b0;
		n_settings    = 0;
		din_ch.valid  = 1'b0;
		din_ch.power  = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = LIM_OVF_ADDR;
		pwdata        = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits first: corners of the power, the fraction and both limits
		foreach (corner_powers[j])
			send_power(corner_powers[j]);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				ovf = ovf_tab[0];
				unf = unf_tab[0];
			end else begin
				// registers change only with the pipe empty
				drain();
				if (ph < 6) begin
					ovf = ovf_tab[ph];
					unf = unf_tab[ph];
				end else begin
					ovf = int'($urandom_range(4095)) - 2048;
					unf = int'($urandom_range(4095)) - 2048;
				end
				write_limit(LIM_OVF_ADDR, ovf);
				write_limit(LIM_UNF_ADDR, unf);
			end
			n_settings++;
			steady = (ph == 3);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_power(rand_power(ovf, unf));
			steady = 1'b0;
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d powers and %0d results over %0d limit settings",
			sb.n_powers, sb.n_results, n_settings);
		$display("%0d overflowed, %0d underflowed, %0d mismatches",
			sb.n_ovf, sb.n_unf, sb.mism);
		if (sb.mism == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
